/* hw/rtl/rmmt_pkg.sv */
// Package for the running maximum / mode tracker.
// Holds sizes, controller states and the controller-to-datapath command type.
// No dependencies.
`default_nettype none

package rmmt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int VALUE_BITS    = 16;
    localparam int COUNT_BITS    = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [0:0] {
        MODE_MAXIMUM  = 1'b0,
        MODE_FREQUENT = 1'b1
    } policy_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic         latch_sample;
        logic         do_match;
        logic         do_read;
        logic         do_update;
        policy_mode_t mode;
    } ctl_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/rmmt_ifs.sv */
// Handshake channel interfaces for the tracker: sample, result and configuration.
// Depends on rmmt_pkg.
`default_nettype none

interface rmmt_sample_if
    import rmmt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface rmmt_result_if
    import rmmt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] best_value;
    logic [COUNT_BITS-1:0] best_count;
    logic                  table_full_drop;

    modport source (output valid, output best_value, output best_count,
                    output table_full_drop, input ready);
    modport sink   (input valid, input best_value, input best_count,
                    input table_full_drop, output ready);
endinterface

interface rmmt_cfg_if;
    logic valid;
    logic ready;
    logic policy_mode;

    modport source (output valid, output policy_mode, input ready);
    modport sink   (input valid, input policy_mode, output ready);
endinterface

`default_nettype wire

/* hw/rtl/running_max_or_mode_tracker.sv */
// Top level of the running maximum / mode tracker.
// Depends on rmmt_pkg, rmmt_ifs, rmmt_ctrl and rmmt_datapath.
//
// One result beat per sample beat. In maximum mode a sample goes from acceptance
// straight to update; in most-frequent mode it steps through accept, parallel
// match over the 64 value cells, count memory read, and update and write-back. The
// next sample is accepted while a result still waits; the update stalls only if that
// result has not been taken. Counts saturate, ties keep the earlier value, and no
// clearing pass follows reset.
`default_nettype none

module running_max_or_mode_tracker
    import rmmt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rmmt_cfg_if.sink      cfg,
    rmmt_sample_if.sink   samples,
    rmmt_result_if.source results
);

    ctl_cmd_t cmd;

    rmmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_mode  (cfg.policy_mode),
        .cfg_ready (cfg.ready),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    rmmt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sample_value    (samples.sample_value),
        .best_value      (results.best_value),
        .best_count      (results.best_count),
        .table_full_drop (results.table_full_drop)
    );

endmodule

`default_nettype wire

/* hw/rtl/rmmt_ctrl.sv */
// Controller for the tracker: sequences match, count read and update per beat,
// holds the policy register and the result valid flag. Depends on rmmt_pkg.
`default_nettype none

module rmmt_ctrl
    import rmmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_valid,
    input  wire logic cfg_mode,
    output logic      cfg_ready,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctl_cmd_t  cmd
);

    ctrl_state_t  state_reg, state_next;
    policy_mode_t mode_reg;
    logic         out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_MAXIMUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                mode_reg <= policy_mode_t'(cfg_mode);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd.latch_sample = 1'b0;
        cmd.do_match     = 1'b0;
        cmd.do_read      = 1'b0;
        cmd.do_update    = 1'b0;
        cmd.mode         = mode_reg;
        in_ready         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_sample = 1'b1;
                    state_next = (mode_reg == MODE_FREQUENT) ? S_MATCH : S_UPDATE;
                end
            end
            S_MATCH:
            begin
                cmd.do_match = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.do_read = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.do_update = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.do_update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_update_frees: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("update did not return to idle with a result");
    a_update_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.do_update)
        else $error("pending result overwritten");
    a_read_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_match |=> cmd.do_read)
        else $error("count read did not follow match");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rmmt_datapath.sv */
// Datapath for the tracker: value cells with parallel match, count memory,
// best value and result payload registers. Depends on rmmt_pkg.
`default_nettype none

module rmmt_datapath
    import rmmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctl_cmd_t              cmd,
    input  wire logic [VALUE_BITS-1:0] sample_value,
    output logic      [VALUE_BITS-1:0] best_value,
    output logic      [COUNT_BITS-1:0] best_count,
    output logic                       table_full_drop
);

    logic [VALUE_BITS-1:0] entry_value_reg [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];
    logic [USED_BITS-1:0]  used_reg, used_next;
    logic [VALUE_BITS-1:0] sample_reg;
    logic [VALUE_BITS-1:0] best_sample_reg, best_sample_next;
    logic [COUNT_BITS-1:0] best_occ_reg, best_occ_next;
    logic                  hit_reg;
    logic                  full_reg;
    logic [IDX_BITS-1:0]   slot_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_drop_reg;

    logic                  match_any;
    logic [IDX_BITS-1:0]   match_slot;
    logic [COUNT_BITS-1:0] bumped_count;
    logic                  drop;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic                  insert;

    // values are unique in the table, so the match vector is one-hot
    always_comb
    begin
        match_any  = 1'b0;
        match_slot = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if ((used_reg > USED_BITS'(i)) && (entry_value_reg[i] == sample_reg))
            begin
                match_any  = 1'b1;
                match_slot = match_slot | IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            bumped_count = (rd_count_reg == COUNT_MAX) ? rd_count_reg
                                                       : rd_count_reg + COUNT_BITS'(1);
        end
        else
        begin
            bumped_count = COUNT_BITS'(1);
        end
        drop             = 1'b0;
        insert           = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = hit_reg ? slot_reg : used_reg[IDX_BITS-1:0];
        used_next        = used_reg;
        best_sample_next = best_sample_reg;
        best_occ_next    = best_occ_reg;
        unique case (cmd.mode)
            MODE_MAXIMUM:
            begin
                if (sample_reg > best_sample_reg)
                begin
                    best_sample_next = sample_reg;
                end
            end
            MODE_FREQUENT:
            begin
                if (!hit_reg && full_reg)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    mem_we = cmd.do_update;
                    insert = cmd.do_update && !hit_reg;
                    if (!hit_reg)
                    begin
                        used_next = used_reg + USED_BITS'(1);
                    end
                    if (bumped_count > best_occ_reg)
                    begin
                        best_sample_next = sample_reg;
                        best_occ_next    = bumped_count;
                    end
                end
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            best_sample_reg <= '0;
            best_occ_reg    <= '0;
        end
        else if (cmd.do_update)
        begin
            used_reg        <= used_next;
            best_sample_reg <= best_sample_next;
            best_occ_reg    <= best_occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_sample)
        begin
            sample_reg <= sample_value;
        end
        if (cmd.do_match)
        begin
            hit_reg  <= match_any;
            slot_reg <= match_slot;
            full_reg <= (used_reg == USED_BITS'(TABLE_ENTRIES));
        end
        if (cmd.do_read)
        begin
            rd_count_reg <= count_mem[slot_reg];
        end
        if (mem_we)
        begin
            count_mem[mem_waddr] <= bumped_count;
        end
        if (insert)
        begin
            entry_value_reg[used_reg[IDX_BITS-1:0]] <= sample_reg;
        end
        if (cmd.do_update)
        begin
            out_value_reg <= best_sample_next;
            out_count_reg <= best_occ_next;
            out_drop_reg  <= drop;
        end
    end

    assign best_value      = out_value_reg;
    assign best_count      = out_count_reg;
    assign table_full_drop = out_drop_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_BITS'(TABLE_ENTRIES))
        else $error("fill count beyond table size");
    a_best_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 best_occ_reg >= $past(best_occ_reg))
        else $error("best count decreased");
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_update && cmd.mode == MODE_MAXIMUM)
        |=> best_sample_reg >= $past(best_sample_reg))
        else $error("maximum decreased");
    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_update && drop) |-> (used_reg == USED_BITS'(TABLE_ENTRIES)))
        else $error("drop with free entries");
`endif

endmodule

`default_nettype wire

/* verif/tb_running_max_or_mode_tracker.sv */
// Testbench for running_max_or_mode_tracker: random and directed samples in both policies.
// Predicts each result beat in a scoreboard class and checks it field by field.
// Depends on rmmt_pkg, rmmt_ifs and the tracker RTL.

import rmmt_pkg::*;

typedef struct packed {
    logic [VALUE_BITS-1:0] best_value;
    logic [COUNT_BITS-1:0] best_count;
    logic                  table_full_drop;
} tracker_result_t;

class tracker_scoreboard;
    policy_mode_t          mode;
    logic [VALUE_BITS-1:0] stored[TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] tally[TABLE_ENTRIES];
    bit                    used[TABLE_ENTRIES];
    int                    filled;
    logic [VALUE_BITS-1:0] top_value;
    logic [COUNT_BITS-1:0] top_count;
    tracker_result_t       pending_q[$];
    int                    errors;

    function new();
        mode = MODE_MAXIMUM;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            stored[i] = '0;
            tally[i]  = '0;
            used[i]   = 1'b0;
        end
        filled    = 0;
        top_value = '0;
        top_count = '0;
        errors    = 0;
    endfunction

    function void set_mode(input policy_mode_t m);
        mode = m;
    endfunction

    function void note_sample(input logic [VALUE_BITS-1:0] v);
        tracker_result_t r;
        int              hit;
        logic            drop;
        drop = 1'b0;
        hit  = -1;
        if (mode == MODE_MAXIMUM)
        begin
            if (v > top_value)
                top_value = v;
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (hit < 0 && used[i] && stored[i] == v)
                    hit = i;
            if (hit < 0 && filled >= TABLE_ENTRIES)
                drop = 1'b1;
            else
            begin
                if (hit < 0)
                begin
                    hit         = filled;
                    stored[hit] = v;
                    tally[hit]  = COUNT_BITS'(1);
                    used[hit]   = 1'b1;
                    filled++;
                end
                else if (tally[hit] != COUNT_MAX)
                    tally[hit] = tally[hit] + COUNT_BITS'(1);
                if (tally[hit] > top_count)
                begin
                    top_value = v;
                    top_count = tally[hit];
                end
            end
        end
        r.best_value      = top_value;
        r.best_count      = top_count;
        r.table_full_drop = drop;
        pending_q.push_back(r);
    endfunction

    function void check_result(input tracker_result_t got);
        tracker_result_t want;
        if (pending_q.size() == 0)
        begin
            errors++;
            $error("result beat with none expected: value %h count %h drop %b",
                   got.best_value, got.best_count, got.table_full_drop);
            return;
        end
        want = pending_q.pop_front();
        if (got.best_value !== want.best_value)
        begin
            errors++;
            $error("best_value: expected %h, got %h", want.best_value, got.best_value);
        end
        if (got.best_count !== want.best_count)
        begin
            errors++;
            $error("best_count: expected %h, got %h", want.best_count, got.best_count);
        end
        if (got.table_full_drop !== want.table_full_drop)
        begin
            errors++;
            $error("table_full_drop: expected %b, got %b",
                   want.table_full_drop, got.table_full_drop);
        end
    endfunction
endclass

module tb_running_max_or_mode_tracker;
    localparam int STUCK_LIMIT = 5000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   calm  = 1'b0;
    int   stuck = 0;

    tracker_scoreboard board = new();

    logic [VALUE_BITS-1:0] pool[96];

    rmmt_cfg_if    cfg_ch();
    rmmt_sample_if smp_ch();
    rmmt_result_if res_ch();

    running_max_or_mode_tracker i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (smp_ch),
        .results (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 31);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result({res_ch.best_value, res_ch.best_count,
                                res_ch.table_full_drop});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stuck <= 0;
            else if (stuck >= STUCK_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stuck <= stuck + 1;
        end
    end

    task automatic push_sample(input logic [VALUE_BITS-1:0] v);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid        <= 1'b1;
        smp_ch.sample_value <= v;
        do
            @(posedge clk);
        while (!smp_ch.ready);
        board.note_sample(v);
    endtask

    task automatic drain_results();
        while (board.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input policy_mode_t m);
        drain_results();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.policy_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.set_mode(m);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [VALUE_BITS-1:0] v;
        int                    n;
        int                    span;
        policy_mode_t          m;
        logic [VALUE_BITS-1:0] max_seq[6];
        logic [VALUE_BITS-1:0] freq_seq[9];

        max_seq  = '{16'h0000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'hFFFF, 16'h0001};
        freq_seq = '{16'h1234, 16'h00FF, 16'h00FF, 16'h1234, 16'h1234,
                     16'hFFFF, 16'h0000, 16'h0000, 16'h0000};

        cfg_ch.valid        <= 1'b0;
        cfg_ch.policy_mode  <= MODE_MAXIMUM;
        smp_ch.valid        <= 1'b0;
        smp_ch.sample_value <= '0;

        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < 96; i++)
            pool[i] = VALUE_BITS'($urandom_range(0, 65535));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (max_seq[i])
            push_sample(max_seq[i]);
        smp_ch.valid <= 1'b0;

        write_mode(MODE_FREQUENT);
        foreach (freq_seq[i])
            push_sample(freq_seq[i]);
        smp_ch.valid <= 1'b0;

        write_mode(MODE_MAXIMUM);
        push_sample(16'h0010);
        push_sample(16'hFFFE);
        smp_ch.valid <= 1'b0;

        write_mode(MODE_FREQUENT);
        push_sample(16'h0010);
        smp_ch.valid <= 1'b0;

        for (int p = 0; p < 12; p++)
        begin
            m = (p % 2 == 0) ? MODE_FREQUENT : MODE_MAXIMUM;
            write_mode(m);
            calm = (p == 5);
            n    = $urandom_range(100, 140);
            span = 16 + p * 7;
            repeat (n)
            begin
                if (m == MODE_FREQUENT && $urandom_range(0, 99) >= 15)
                    v = pool[$urandom_range(0, $urandom_range(0, span))];
                else
                    v = VALUE_BITS'($urandom);
                push_sample(v);
            end
            smp_ch.valid <= 1'b0;
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/rmmt_pkg.sv
hw/rtl/rmmt_ifs.sv
hw/rtl/rmmt_ctrl.sv
hw/rtl/rmmt_datapath.sv
hw/rtl/running_max_or_mode_tracker.sv
verif/tb_running_max_or_mode_tracker.sv
